// ===== hdl/srt_pkg.sv =====
// Package: sizes, item types, request and part codes, part layout helpers for the record table.
package srt_pkg;

  localparam int CAPACITY      = 64;
  localparam int TITLE_LEN     = 50;
  localparam int AUTHOR_LEN    = 20;
  localparam int PUBLISHER_LEN = 30;
  localparam int DATE_LEN      = 10;
  localparam int REC_LEN       = TITLE_LEN + AUTHOR_LEN + PUBLISHER_LEN + DATE_LEN;

  localparam int STORE_DEPTH = CAPACITY * REC_LEN;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int STG_AW      = $clog2(REC_LEN);
  localparam int PAT_AW      = $clog2(TITLE_LEN);
  localparam int K_W         = $clog2(TITLE_LEN + 1);
  localparam int J_W         = $clog2(((REC_LEN > CAPACITY) ? REC_LEN : CAPACITY) + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] PART_TITLE     = 2'd0;
  localparam logic [1:0] PART_AUTHOR    = 2'd1;
  localparam logic [1:0] PART_PUBLISHER = 2'd2;
  localparam logic [1:0] PART_DATE      = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] part;
    logic [5:0] char_pos;
    logic [7:0] char_value;
    logic [5:0] record_index;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] match_mask;
    logic [6:0]  removed_count;
    logic [7:0]  read_char;
    logic [6:0]  entry_count;
  } out_item_t;

  // Length of a record part in bytes
  function automatic logic [6:0] part_len(input logic [1:0] p);
    logic [6:0] r;
    case (p)
      PART_TITLE:     r = 7'(TITLE_LEN);
      PART_AUTHOR:    r = 7'(AUTHOR_LEN);
      PART_PUBLISHER: r = 7'(PUBLISHER_LEN);
      default:        r = 7'(DATE_LEN);
    endcase
    return r;
  endfunction

  // Byte offset of a record part within the record
  function automatic logic [7:0] part_off(input logic [1:0] p);
    logic [7:0] r;
    case (p)
      PART_TITLE:     r = 8'd0;
      PART_AUTHOR:    r = 8'(TITLE_LEN);
      PART_PUBLISHER: r = 8'(TITLE_LEN + AUTHOR_LEN);
      default:        r = 8'(TITLE_LEN + AUTHOR_LEN + PUBLISHER_LEN);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/srt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module srt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sorted_record_table_top.sv =====
// Top level: sorted text record table with byte-serial insert, byte read, substring search and delete.
//
// Characters that do not end an insert or pattern are only stored on acceptance. All other
// work is byte-serial through single-port reads of the order, staging, pattern and record
// stores: a read answers at once when out of range and otherwise reads the order list and
// then the stored byte; a final insert character copies the staged record into a free slot
// and then compares its title, byte by byte, with the records before it until it finds its
// place; a final search or delete character first measures the pattern, then per record
// compares pattern and title bytes at each offset, and a delete then appends the removed
// records. The staging, pattern and order stores carry per-entry valid bits, so reset needs
// no clearing pass. A result may wait in the output register; the next item is taken once
// it is taken or leaving.
module sorted_record_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srt_pkg::out_item_t out_data
);
  import srt_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RD_ORD    = 5'd1;
  localparam logic [4:0] S_RD_ORD_EV = 5'd2;
  localparam logic [4:0] S_RD_ST     = 5'd3;
  localparam logic [4:0] S_RD_ST_EV  = 5'd4;
  localparam logic [4:0] S_INS_ORD   = 5'd5;
  localparam logic [4:0] S_INS_EV    = 5'd6;
  localparam logic [4:0] S_CPY       = 5'd7;
  localparam logic [4:0] S_CPY_EV    = 5'd8;
  localparam logic [4:0] S_SORT      = 5'd9;
  localparam logic [4:0] S_SORT_EV   = 5'd10;
  localparam logic [4:0] S_CMP       = 5'd11;
  localparam logic [4:0] S_CMP_EV    = 5'd12;
  localparam logic [4:0] S_PLEN      = 5'd13;
  localparam logic [4:0] S_PLEN_EV   = 5'd14;
  localparam logic [4:0] S_REC       = 5'd15;
  localparam logic [4:0] S_REC_EV    = 5'd16;
  localparam logic [4:0] S_MCMP      = 5'd17;
  localparam logic [4:0] S_MCMP_EV   = 5'd18;
  localparam logic [4:0] S_CPT       = 5'd19;
  localparam logic [4:0] S_CPT_EV    = 5'd20;

  logic [4:0]          state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  logic [REC_LEN-1:0]  svalid_r;
  logic [TITLE_LEN-1:0] pvalid_r;
  logic [CAPACITY-1:0] ovalid_r;

  logic [SLOT_W-1:0]   idx_r, cur_r, slot_r, prev_r;
  logic [STG_AW-1:0]   off_r;
  logic [J_W-1:0]      j_r;
  logic [CNT_W-1:0]    p_r, i_r, nk_r, ng_r;
  logic [K_W-1:0]      k_r, o_r, plen_r;
  logic [CAPACITY-1:0] mask_r;
  logic                remove_r;

  logic                svq_r, pvq_r, ovq_r;
  logic [SLOT_W-1:0]   ord_raq_r;

  // Memory ports
  logic                st_we;
  logic [STORE_AW-1:0] st_waddr, st_raddr;
  logic [7:0]          st_wdata, st_rdata;
  logic                stg_we;
  logic [STG_AW-1:0]   stg_waddr, stg_raddr;
  logic [7:0]          stg_rdata;
  logic                pat_we;
  logic [PAT_AW-1:0]   pat_waddr, pat_raddr;
  logic [7:0]          pat_rdata;
  logic                ord_we;
  logic [SLOT_W-1:0]   ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic                gone_we;
  logic [SLOT_W-1:0]   gone_waddr, gone_raddr, gone_rdata;

  logic                in_fire;
  logic                pos_in_part, pos_in_title, rd_in_range;
  logic [SLOT_W-1:0]   ord_rd;
  logic [7:0]          stg_rd, pat_rd;
  logic                cmp_shift, cmp_stop;
  logic                eq, hit, bound_fail, match_ev, nomatch_ev;

  function automatic logic [STORE_AW-1:0] st_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [8:0] off);
    return STORE_AW'(int'(s) * REC_LEN + int'(off));
  endfunction

  function automatic out_item_t mk_out(input logic st, input logic [63:0] m,
                                       input logic [6:0] rem, input logic [7:0] rc,
                                       input logic [6:0] ec);
    out_item_t o;
    o.status        = st;
    o.match_mask    = m;
    o.removed_count = rem;
    o.read_char     = rc;
    o.entry_count   = ec;
    return o;
  endfunction

  srt_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  srt_ram #(.DEPTH(REC_LEN), .WIDTH(8)) u_staging (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(in_data.char_value),
    .raddr(stg_raddr), .rdata(stg_rdata)
  );
  srt_ram #(.DEPTH(TITLE_LEN), .WIDTH(8)) u_pattern (
    .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(in_data.char_value),
    .raddr(pat_raddr), .rdata(pat_rdata)
  );
  srt_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );
  srt_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_gone (
    .clk(clk), .we(gone_we), .waddr(gone_waddr), .wdata(cur_r),
    .raddr(gone_raddr), .rdata(gone_rdata)
  );

  // Handshake
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode of the incoming item
  assign pos_in_part  = {1'b0, in_data.char_pos} < part_len(in_data.part);
  assign pos_in_title = 7'(in_data.char_pos) < 7'(TITLE_LEN);
  assign rd_in_range  = pos_in_part && ({1'b0, in_data.record_index} < 7'(cnt_r));

  // Unwritten entries read as their reset values
  assign ord_rd = ovq_r ? ord_rdata : ord_raq_r;
  assign stg_rd = svq_r ? stg_rdata : 8'd0;
  assign pat_rd = pvq_r ? pat_rdata : 8'd0;

  // Title compare for insert: new title against the record before position p
  assign cmp_shift = stg_rd < st_rdata;
  assign cmp_stop  = (stg_rd > st_rdata) ||
                     ((stg_rd == 8'd0) || (k_r == K_W'(TITLE_LEN - 1)));

  // Substring match events
  assign eq         = st_rdata == pat_rd;
  assign hit        = eq && ((k_r + 1'b1) == plen_r);
  assign bound_fail = ({1'b0, o_r} + {1'b0, plen_r}) > (K_W + 1)'(TITLE_LEN);
  assign match_ev   = ((state_r == S_MCMP) && (plen_r == '0)) ||
                      ((state_r == S_MCMP_EV) && hit);
  assign nomatch_ev = ((state_r == S_MCMP) && (plen_r != '0) && bound_fail) ||
                      ((state_r == S_MCMP_EV) && !eq && (st_rdata == 8'd0));

  // Staging and pattern writes on accepted characters
  assign stg_we    = in_fire && (in_data.req_type == REQ_INSERT) && pos_in_part;
  assign stg_waddr = STG_AW'(part_off(in_data.part) + {2'b00, in_data.char_pos});
  assign pat_we    = in_fire && ((in_data.req_type == REQ_SEARCH) ||
                                 (in_data.req_type == REQ_DELETE)) && pos_in_title;
  assign pat_waddr = PAT_AW'(in_data.char_pos);

  // Read addresses per state
  always_comb begin
    ord_raddr  = '0;
    st_raddr   = '0;
    stg_raddr  = '0;
    pat_raddr  = '0;
    gone_raddr = '0;
    case (state_r)
      S_RD_ORD, S_RD_ORD_EV: ord_raddr = idx_r;
      S_RD_ST, S_RD_ST_EV:   st_raddr  = st_addr(cur_r, {1'b0, 8'(off_r)});
      S_INS_ORD, S_INS_EV:   ord_raddr = SLOT_W'(cnt_r);
      S_CPY, S_CPY_EV:       stg_raddr = STG_AW'(j_r);
      S_SORT, S_SORT_EV:     ord_raddr = SLOT_W'(p_r - 1'b1);
      S_CMP, S_CMP_EV: begin
        stg_raddr = STG_AW'(k_r);
        st_raddr  = st_addr(prev_r, 9'(k_r));
      end
      S_PLEN, S_PLEN_EV:     pat_raddr = PAT_AW'(k_r);
      S_REC, S_REC_EV:       ord_raddr = SLOT_W'(i_r);
      S_MCMP, S_MCMP_EV: begin
        pat_raddr = PAT_AW'(k_r);
        st_raddr  = st_addr(cur_r, 9'({1'b0, o_r} + {1'b0, k_r}));
      end
      S_CPT, S_CPT_EV:       gone_raddr = SLOT_W'(j_r);
      default: ;
    endcase
  end

  // Store, order and removed-list writes
  always_comb begin
    st_we     = (state_r == S_CPY_EV);
    st_waddr  = st_addr(slot_r, 9'(j_r));
    st_wdata  = stg_rd;
    ord_we    = 1'b0;
    ord_waddr = SLOT_W'(p_r);
    ord_wdata = slot_r;
    case (state_r)
      S_SORT:   ord_we = (p_r == '0);
      S_CMP_EV: begin
        ord_we = cmp_shift || cmp_stop;
        if (cmp_shift) begin
          ord_wdata = prev_r;
        end
      end
      S_MCMP, S_MCMP_EV: begin
        ord_we    = nomatch_ev && remove_r;
        ord_waddr = SLOT_W'(nk_r);
        ord_wdata = cur_r;
      end
      S_CPT_EV: begin
        ord_we    = 1'b1;
        ord_waddr = SLOT_W'(nk_r + j_r);
        ord_wdata = gone_rdata;
      end
      default: ;
    endcase
    gone_we    = match_ev && remove_r;
    gone_waddr = SLOT_W'(ng_r);
  end

  // Track valid bits alongside the registered read data
  always_ff @(posedge clk) begin
    ord_raq_r <= ord_raddr;
    ovq_r     <= ovalid_r[ord_raddr];
    svq_r     <= svalid_r[stg_raddr];
    pvq_r     <= pvalid_r[pat_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      svalid_r    <= '0;
      pvalid_r    <= '0;
      ovalid_r    <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (stg_we) begin
        svalid_r[stg_waddr] <= 1'b1;
      end
      if (pat_we) begin
        pvalid_r[pat_waddr] <= 1'b1;
      end
      if (ord_we) begin
        ovalid_r[ord_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.req_type)
              REQ_READ: begin
                if (rd_in_range) begin
                  idx_r   <= in_data.record_index[SLOT_W-1:0];
                  off_r   <= stg_waddr;
                  state_r <= S_RD_ORD;
                end else begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(1'b0, 64'd0, 7'd0, 8'd0, 7'(cnt_r));
                end
              end
              REQ_INSERT: begin
                if (in_data.last) begin
                  if (cnt_r == CNT_W'(CAPACITY)) begin
                    svalid_r    <= '0;
                    out_valid_r <= 1'b1;
                    out_data_r  <= mk_out(1'b1, 64'd0, 7'd0, 8'd0, 7'(cnt_r));
                  end else begin
                    state_r <= S_INS_ORD;
                  end
                end
              end
              default: begin
                if (in_data.last) begin
                  remove_r <= (in_data.req_type == REQ_DELETE);
                  k_r      <= '0;
                  state_r  <= S_PLEN;
                end
              end
            endcase
          end
        end
        // Read one stored byte
        S_RD_ORD:    state_r <= S_RD_ORD_EV;
        S_RD_ORD_EV: begin
          cur_r   <= ord_rd;
          state_r <= S_RD_ST;
        end
        S_RD_ST:     state_r <= S_RD_ST_EV;
        S_RD_ST_EV: begin
          out_valid_r <= 1'b1;
          out_data_r  <= mk_out(1'b0, 64'd0, 7'd0, st_rdata, 7'(cnt_r));
          state_r     <= S_IDLE;
        end
        // Take a free slot and copy the staged record into it
        S_INS_ORD:   state_r <= S_INS_EV;
        S_INS_EV: begin
          slot_r  <= ord_rd;
          j_r     <= '0;
          state_r <= S_CPY;
        end
        S_CPY:       state_r <= S_CPY_EV;
        S_CPY_EV: begin
          if (j_r == J_W'(REC_LEN - 1)) begin
            p_r     <= cnt_r;
            state_r <= S_SORT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_CPY;
          end
        end
        // Walk down the order list, shifting larger titles up
        S_SORT: begin
          if (p_r == '0) begin
            cnt_r       <= cnt_r + 1'b1;
            svalid_r    <= '0;
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(1'b0, 64'd0, 7'd0, 8'd0, 7'(cnt_r + 1'b1));
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_SORT_EV;
          end
        end
        S_SORT_EV: begin
          prev_r  <= ord_rd;
          k_r     <= '0;
          state_r <= S_CMP;
        end
        S_CMP:       state_r <= S_CMP_EV;
        S_CMP_EV: begin
          if (cmp_shift) begin
            p_r     <= p_r - 1'b1;
            state_r <= S_SORT;
          end else if (cmp_stop) begin
            cnt_r       <= cnt_r + 1'b1;
            svalid_r    <= '0;
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(1'b0, 64'd0, 7'd0, 8'd0, 7'(cnt_r + 1'b1));
            state_r     <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_CMP;
          end
        end
        // Measure the pattern
        S_PLEN:      state_r <= S_PLEN_EV;
        S_PLEN_EV: begin
          if ((pat_rd == 8'd0) || (k_r == K_W'(TITLE_LEN - 1))) begin
            plen_r  <= (pat_rd == 8'd0) ? k_r : K_W'(TITLE_LEN);
            i_r     <= '0;
            nk_r    <= '0;
            ng_r    <= '0;
            mask_r  <= '0;
            state_r <= S_REC;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PLEN;
          end
        end
        // Visit each live record in sorted order
        S_REC: begin
          if (i_r == cnt_r) begin
            j_r <= '0;
            if (remove_r) begin
              state_r <= S_CPT;
            end else begin
              pvalid_r    <= '0;
              out_valid_r <= 1'b1;
              out_data_r  <= mk_out(1'b0, 64'(mask_r), 7'd0, 8'd0, 7'(cnt_r));
              state_r     <= S_IDLE;
            end
          end else begin
            state_r <= S_REC_EV;
          end
        end
        S_REC_EV: begin
          cur_r   <= ord_rd;
          o_r     <= '0;
          k_r     <= '0;
          state_r <= S_MCMP;
        end
        S_MCMP, S_MCMP_EV: begin
          if (match_ev) begin
            mask_r[SLOT_W'(i_r)] <= 1'b1;
            if (remove_r) begin
              ng_r <= ng_r + 1'b1;
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_REC;
          end else if (nomatch_ev) begin
            if (remove_r) begin
              nk_r <= nk_r + 1'b1;
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_REC;
          end else if (state_r == S_MCMP) begin
            state_r <= S_MCMP_EV;
          end else if (eq) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MCMP;
          end else begin
            o_r     <= o_r + 1'b1;
            k_r     <= '0;
            state_r <= S_MCMP;
          end
        end
        // Append removed slots after the kept ones
        S_CPT: begin
          if (j_r == J_W'(ng_r)) begin
            cnt_r       <= nk_r;
            pvalid_r    <= '0;
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(1'b0, 64'(mask_r), 7'(ng_r), 8'd0, 7'(nk_r));
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_CPT_EV;
          end
        end
        S_CPT_EV: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_CPT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_EV) |-> (p_r != '0))
    else $error("title compare at sorted position zero");

  a_split_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REC) && remove_r) |-> ((nk_r + ng_r) == i_r))
    else $error("kept and removed counts do not cover visited records");

  a_cpt_del: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPT_EV) |-> remove_r)
    else $error("order compaction outside a delete");

endmodule

// ===== sim/tb_sorted_record_table_top.sv =====
// Testbench for the sorted record table: directed and random requests against a local predictor.
`timescale 1ns / 100ps

module tb_sorted_record_table_top;
  import srt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  sorted_record_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: records held in sorted order, plus the streaming buffers
  typedef logic [7:0] rec_t [REC_LEN];
  rec_t       table_recs [$];
  logic [7:0] stage_bytes [REC_LEN];
  logic [7:0] pat_bytes [TITLE_LEN];

  out_item_t  expected_results [$];
  int         fail_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         idle_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int title_length(rec_t r);
    int n;
    n = 0;
    while (n < TITLE_LEN && r[n] != 8'd0) n++;
    return n;
  endfunction

  // Unsigned byte-wise title ordering of two records
  function automatic int title_order(rec_t a, rec_t b);
    for (int i = 0; i < TITLE_LEN; i++) begin
      if (a[i] != b[i]) return (a[i] < b[i]) ? -1 : 1;
      if (a[i] == 8'd0) return 0;
    end
    return 0;
  endfunction

  function automatic bit title_contains(rec_t r, int plen);
    int  tl;
    bit  hit;
    tl = title_length(r);
    if (plen == 0) return 1'b1;
    for (int o = 0; o + plen <= tl; o++) begin
      hit = 1'b1;
      for (int k = 0; k < plen; k++)
        if (r[o + k] != pat_bytes[k]) hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int part_length(logic [1:0] p);
    case (p)
      PART_TITLE:     return TITLE_LEN;
      PART_AUTHOR:    return AUTHOR_LEN;
      PART_PUBLISHER: return PUBLISHER_LEN;
      default:        return DATE_LEN;
    endcase
  endfunction

  function automatic int part_offset(logic [1:0] p);
    case (p)
      PART_TITLE:     return 0;
      PART_AUTHOR:    return TITLE_LEN;
      PART_PUBLISHER: return TITLE_LEN + AUTHOR_LEN;
      default:        return TITLE_LEN + AUTHOR_LEN + PUBLISHER_LEN;
    endcase
  endfunction

  // Update the table model for one accepted item; queue any result it causes
  task automatic predict_table(in_item_t it);
    out_item_t r;
    rec_t      nr;
    rec_t      kept [$];
    int        p;
    int        plen;
    r = '0;
    if (it.req_type == REQ_READ) begin
      if (it.record_index < table_recs.size() && it.char_pos < part_length(it.part))
        r.read_char = table_recs[it.record_index][part_offset(it.part) + it.char_pos];
    end else if (it.req_type == REQ_INSERT) begin
      if (it.char_pos < part_length(it.part))
        stage_bytes[part_offset(it.part) + it.char_pos] = it.char_value;
      if (!it.last) return;
      if (table_recs.size() >= CAPACITY) begin
        r.status = 1'b1;
      end else begin
        nr = stage_bytes;
        p = table_recs.size();
        while (p > 0 && title_order(nr, table_recs[p - 1]) < 0) p--;
        table_recs.insert(p, nr);
      end
      foreach (stage_bytes[i]) stage_bytes[i] = 8'd0;
    end else begin
      if (it.char_pos < TITLE_LEN) pat_bytes[it.char_pos] = it.char_value;
      if (!it.last) return;
      plen = 0;
      while (plen < TITLE_LEN && pat_bytes[plen] != 8'd0) plen++;
      foreach (table_recs[i]) begin
        if (title_contains(table_recs[i], plen)) r.match_mask[i] = 1'b1;
        else kept.push_back(table_recs[i]);
      end
      if (it.req_type == REQ_DELETE) begin
        r.removed_count = 7'(table_recs.size() - kept.size());
        table_recs = kept;
      end
      foreach (pat_bytes[i]) pat_bytes[i] = 8'd0;
    end
    r.entry_count = 7'(table_recs.size());
    expected_results.push_back(r);
  endtask

  // Send one item, idling first at random; valid drops only while idling or draining
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table(it);
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] rq, logic [1:0] pt, int pos,
                                         logic [7:0] ch, int idx, bit lst);
    in_item_t it;
    it.req_type     = rq;
    it.part         = pt;
    it.char_pos     = 6'(pos);
    it.char_value   = ch;
    it.record_index = 6'(idx);
    it.last         = lst;
    return it;
  endfunction

  // Stream a string; a zero-length string still needs one last byte
  task automatic send_string(logic [1:0] rq, logic [1:0] pt, string s, bit finish);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++)
      send_item(make_item(rq, pt, i, s[i], $urandom_range(63), finish && i == n - 1));
    if (n == 0 && finish) send_item(make_item(rq, pt, 0, 8'd0, 0, 1'b1));
  endtask

  task automatic insert_record(string title, string author);
    send_string(REQ_INSERT, PART_AUTHOR, author, 1'b0);
    send_string(REQ_INSERT, PART_TITLE, title, 1'b1);
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic string rand_text(int maxlen);
    string s;
    s = "";
    repeat ($urandom_range(maxlen)) s = {s, string'(8'("a" + $urandom_range(2)))};
    return s;
  endfunction

  // Directed: part bounds, stable order, empty pattern, reads out of range
  task automatic test_directed();
    insert_record("mid", "x");
    insert_record("abc", "y");
    insert_record("mid", "z");
    send_item(make_item(REQ_INSERT, PART_DATE, 9, 8'hff, 0, 1'b0));
    send_item(make_item(REQ_INSERT, PART_DATE, 63, 8'h80, 0, 1'b0));
    send_item(make_item(REQ_INSERT, PART_TITLE, 49, 8'hff, 0, 1'b0));
    send_item(make_item(REQ_INSERT, PART_TITLE, 0, 8'h01, 0, 1'b1));
    send_item(make_item(REQ_READ, PART_AUTHOR, 0, 8'h00, 2, 1'b0));
    send_item(make_item(REQ_READ, PART_DATE, 9, 8'h00, 0, 1'b1));
    send_item(make_item(REQ_READ, PART_TITLE, 49, 8'h00, 0, 1'b0));
    send_item(make_item(REQ_READ, PART_TITLE, 0, 8'h00, 63, 1'b0));
    send_item(make_item(REQ_READ, PART_PUBLISHER, 30, 8'h00, 1, 1'b0));
    send_item(make_item(REQ_SEARCH, PART_TITLE, 60, 8'h55, 0, 1'b0));
    send_string(REQ_SEARCH, PART_TITLE, "id", 1'b1);
    send_string(REQ_DELETE, PART_TITLE, "b", 1'b0);
    send_item(make_item(REQ_SEARCH, PART_TITLE, 1, 8'h00, 0, 1'b1));
    send_string(REQ_SEARCH, PART_TITLE, "", 1'b1);
    send_string(REQ_DELETE, PART_TITLE, "abc", 1'b1);
    wait_drained();
  endtask

  // Fill past capacity so the full flag shows, then empty with a blank pattern
  task automatic test_full_table();
    for (int i = 0; i <= CAPACITY; i++)
      send_item(make_item(REQ_INSERT, PART_TITLE, 0, 8'($urandom_range(255)), 0, 1'b1));
    send_item(make_item(REQ_READ, PART_TITLE, 0, 8'h00, 63, 1'b0));
    send_string(REQ_DELETE, PART_TITLE, "", 1'b1);
    wait_drained();
  endtask

  // Random: mostly well-formed records and patterns, some raw noise
  task automatic test_random(int n_items);
    int sent;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          insert_record(rand_text(4), rand_text(2));
          sent += 4;
        end
        4, 5: begin
          send_string(REQ_SEARCH, PART_TITLE, rand_text(2), 1'b1);
          sent += 2;
        end
        6: begin
          send_string(REQ_DELETE, PART_TITLE, rand_text(2) == "" ? "c" : rand_text(3), 1'b1);
          sent += 2;
        end
        7, 8: begin
          send_item(make_item(REQ_READ, 2'($urandom_range(3)), $urandom_range(63),
                              8'($urandom_range(255)), $urandom_range(
                              table_recs.size() > 0 ? table_recs.size() : 1), 1'b0));
          sent++;
        end
        default: begin
          it = in_item_t'($bits(in_item_t)'($urandom));
          if (it.req_type == REQ_READ && it.record_index >= table_recs.size())
            it.record_index = 6'(table_recs.size());
          send_item(it);
          sent++;
        end
      endcase
    end
    wait_drained();
  endtask

  // Result receiver and checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status exp %0h got %0h", e.status, out_data.status); fail_count++;
        end
        if (out_data.match_mask !== e.match_mask) begin
          $error("match_mask exp %h got %h", e.match_mask, out_data.match_mask); fail_count++;
        end
        if (out_data.removed_count !== e.removed_count) begin
          $error("removed_count exp %0d got %0d", e.removed_count, out_data.removed_count);
          fail_count++;
        end
        if (out_data.read_char !== e.read_char) begin
          $error("read_char exp %0h got %0h", e.read_char, out_data.read_char); fail_count++;
        end
        if (out_data.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Drive ready at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    send_idle_pct = 14;
    recv_idle_pct = 75;
    foreach (stage_bytes[i]) stage_bytes[i] = 8'd0;
    foreach (pat_bytes[i]) pat_bytes[i] = 8'd0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_random(14);
    send_idle_pct = 75;
    recv_idle_pct = 14;
    test_random(14);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(15);

    wait_drained();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
